[rtl/core/ssfc_pkg.sv]
// ----------------------------------------------------------------------------
// ssfc_pkg
// Shared types and constants for the sensor stream frame checker: beat
// payloads, frame phase encoding, result kinds and register map.
// ----------------------------------------------------------------------------
package ssfc_pkg;

  // header byte value after reset
  localparam logic [7:0] HeaderReset = 8'h13;

  // configuration register map (word index)
  localparam int unsigned CfgAddrW = 2;
  localparam logic [CfgAddrW-1:0] RegHeaderValue = '0;

  // result kinds
  localparam logic KindPayload  = 1'b0;
  localparam logic KindFrameEnd = 1'b1;

  // frame parser phase
  typedef enum logic [1:0] {
    PhHunt    = 2'd0,
    PhLength  = 2'd1,
    PhPayload = 2'd2,
    PhCheck   = 2'd3
  } ssfc_phase_t;

  // input beat payload
  typedef struct packed {
    logic [7:0] rx_byte;
  } ssfc_in_t;

  // result beat payload
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_ok;
  } ssfc_out_t;

endpackage

[rtl/core/ssfc_in_if.sv]
// ----------------------------------------------------------------------------
// ssfc_in_if
// Valid/ready channel carrying received serial bytes.
// ----------------------------------------------------------------------------
interface ssfc_in_if;

  logic               valid;
  logic               ready;
  ssfc_pkg::ssfc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

[rtl/core/ssfc_out_if.sv]
// ----------------------------------------------------------------------------
// ssfc_out_if
// Valid/ready channel carrying payload byte and frame end results.
// ----------------------------------------------------------------------------
interface ssfc_out_if;

  logic                valid;
  logic                ready;
  ssfc_pkg::ssfc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

[rtl/core/sensor_stream_frame_checker.sv]
// ----------------------------------------------------------------------------
// sensor_stream_frame_checker
// Takes one received byte per beat and parses length-prefixed frames: the
// header byte (register header_value, reset 0x13), a length byte L, L payload
// bytes and a checksum byte. Bytes outside a frame that do not match the
// header are dropped. Each payload byte comes out as a result with its index;
// the checksum byte gives a frame end result carrying L and frame_ok, set
// when header + length + payload + checksum is zero modulo 256. Each byte is
// handled on the beat that accepts it: the frame state and the result
// register update then, so a byte can be accepted in every cycle while the
// result side takes its beats. Input ready drops only while a result sits
// unread in the single output register. Write header_value only while idle.
// ----------------------------------------------------------------------------
module sensor_stream_frame_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  ssfc_in_if.sink                       in_ch,
  ssfc_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssfc_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import ssfc_pkg::*;

  // configuration
  logic [7:0] header_value_r;

  // frame state
  ssfc_phase_t phase_r, phase_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  frame_length_r, frame_length_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;

  // result register
  logic       out_valid_r;
  ssfc_out_t  out_data_r;
  ssfc_out_t  res_data;
  logic       res_valid;

  logic       in_fire;
  logic       cfg_write;
  logic [7:0] rx_byte;
  logic [7:0] sum_add;
  logic [7:0] left_dec;

  assign rx_byte  = in_ch.data.rx_byte;
  assign sum_add  = running_sum_r + rx_byte;
  assign left_dec = bytes_left_r - 8'd1;

  // handshakes
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // apb register access
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == RegHeaderValue);
  assign prdata    = {24'd0, header_value_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_value_r <= HeaderReset;
    end else if (cfg_write) begin
      header_value_r <= pwdata[7:0];
    end
  end

  // next frame state
  always_comb begin
    phase_nxt        = phase_r;
    bytes_left_nxt   = bytes_left_r;
    frame_length_nxt = frame_length_r;
    running_sum_nxt  = running_sum_r;
    unique case (phase_r)
      PhHunt: begin
        if (rx_byte == header_value_r) begin
          running_sum_nxt = rx_byte;
          phase_nxt       = PhLength;
        end
      end
      PhLength: begin
        frame_length_nxt = rx_byte;
        bytes_left_nxt   = rx_byte;
        running_sum_nxt  = sum_add;
        phase_nxt        = (rx_byte == 8'd0) ? PhCheck : PhPayload;
      end
      PhPayload: begin
        running_sum_nxt = sum_add;
        bytes_left_nxt  = left_dec;
        if (left_dec == 8'd0) begin
          phase_nxt = PhCheck;
        end
      end
      PhCheck: begin
        running_sum_nxt = sum_add;
        bytes_left_nxt  = 8'd0;
        phase_nxt       = PhHunt;
      end
      default: begin
        phase_nxt = PhHunt;
      end
    endcase
  end

  // result for the current byte
  always_comb begin
    res_valid              = 1'b0;
    res_data.kind          = KindPayload;
    res_data.payload_byte  = 8'd0;
    res_data.payload_index = 8'd0;
    res_data.frame_ok      = 1'b0;
    unique case (phase_r) inside
      PhHunt, PhLength: begin
        res_valid = 1'b0;
      end
      PhPayload: begin
        res_valid              = 1'b1;
        res_data.payload_byte  = rx_byte;
        res_data.payload_index = frame_length_r - bytes_left_r;
      end
      PhCheck: begin
        res_valid              = 1'b1;
        res_data.kind          = KindFrameEnd;
        res_data.payload_index = frame_length_r;
        res_data.frame_ok      = (sum_add == 8'd0);
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // state update on accepted beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PhHunt;
      bytes_left_r   <= 8'd0;
      frame_length_r <= 8'd0;
      running_sum_r  <= 8'd0;
    end else if (in_fire) begin
      phase_r        <= phase_nxt;
      bytes_left_r   <= bytes_left_nxt;
      frame_length_r <= frame_length_nxt;
      running_sum_r  <= running_sum_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_data_r <= res_data;
    end
  end

endmodule
